[rtl/bhpq_pkg.sv]
package bhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 16;

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W   = COUNT_W + 1;

  localparam int POS_W  = 10;
  localparam int COST_W = 16;
  localparam int MEM_W  = 16;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [COST_W-1:0] cost;
    logic [MEM_W-1:0]  memory;
  } entry_t;

  typedef struct packed {
    logic              command;
    logic [POS_W-1:0]  item_position;
    logic [COST_W-1:0] item_cost;
    logic [MEM_W-1:0]  item_memory;
  } in_item_t;

  typedef struct packed {
    logic               top_valid;
    logic [POS_W-1:0]   top_position;
    logic [COST_W-1:0]  top_cost;
    logic [MEM_W-1:0]   top_memory;
    logic [COUNT_W-1:0] entry_count;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD_PUSH,
    DP_LOAD_POP,
    DP_SET_FULL,
    DP_SET_EMPTY,
    DP_PARENT_MOVE,
    DP_PUT_ITEM,
    DP_TAKE_MOVING,
    DP_LATCH_LEFT,
    DP_CHILD_MOVE,
    DP_PUT_MOVING,
    DP_LOAD_RESULT
  } dp_op_t;

  typedef enum logic [1:0] {
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic k_is_root;
    logic parent_after;
    logic has_left;
    logic move_down;
    logic count_nonzero;
    logic out_busy;
  } dp_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_CHK,
    S_PUSH_CMP,
    S_POP_TAKE,
    S_POP_CHK,
    S_POP_LEFT,
    S_POP_CMP,
    S_RESULT
  } state_t;

  // True when a must sit below b: a is strictly greater on cost, then memory.
  function automatic logic entry_after(entry_t a, entry_t b);
    logic [KEY_BITS-1:0] ac;
    logic [KEY_BITS-1:0] bc;
    logic [KEY_BITS-1:0] am;
    logic [KEY_BITS-1:0] bm;
    ac = a.cost[KEY_BITS-1:0];
    bc = b.cost[KEY_BITS-1:0];
    am = a.memory[KEY_BITS-1:0];
    bm = b.memory[KEY_BITS-1:0];
    if (ac == bc) begin
      return am > bm;
    end
    return ac > bc;
  endfunction

endpackage

[rtl/bhpq_ctrl.sv]
module bhpq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_command,
  output logic             in_ready,
  input  bhpq_pkg::dp_sts_t sts,
  output bhpq_pkg::dp_cmd_t cmd
);
  import bhpq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = DP_NOP;
    cmd.rd_sel = RD_PARENT;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_PUSH) begin
            if (sts.full) begin
              cmd.op    = DP_SET_FULL;
              state_nxt = S_RESULT;
            end else begin
              cmd.op    = DP_LOAD_PUSH;
              state_nxt = S_PUSH_CHK;
            end
          end else begin
            if (sts.empty) begin
              cmd.op    = DP_SET_EMPTY;
              state_nxt = S_RESULT;
            end else begin
              cmd.op     = DP_LOAD_POP;
              cmd.rd_sel = RD_LAST;
              state_nxt  = S_POP_TAKE;
            end
          end
        end
      end
      S_PUSH_CHK: begin
        if (sts.k_is_root) begin
          cmd.op    = DP_PUT_ITEM;
          state_nxt = S_RESULT;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        if (sts.parent_after) begin
          cmd.op    = DP_PARENT_MOVE;
          state_nxt = S_PUSH_CHK;
        end else begin
          cmd.op    = DP_PUT_ITEM;
          state_nxt = S_RESULT;
        end
      end
      S_POP_TAKE: begin
        cmd.op    = DP_TAKE_MOVING;
        state_nxt = S_POP_CHK;
      end
      S_POP_CHK: begin
        if (sts.has_left) begin
          cmd.rd_sel = RD_LEFT;
          state_nxt  = S_POP_LEFT;
        end else begin
          if (sts.count_nonzero) begin
            cmd.op = DP_PUT_MOVING;
          end
          state_nxt = S_RESULT;
        end
      end
      S_POP_LEFT: begin
        cmd.op     = DP_LATCH_LEFT;
        cmd.rd_sel = RD_RIGHT;
        state_nxt  = S_POP_CMP;
      end
      S_POP_CMP: begin
        if (sts.move_down) begin
          cmd.op    = DP_CHILD_MOVE;
          state_nxt = S_POP_CHK;
        end else begin
          cmd.op    = DP_PUT_MOVING;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.op    = DP_LOAD_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/bhpq_datapath.sv]
module bhpq_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  bhpq_pkg::dp_cmd_t  cmd,
  input  bhpq_pkg::in_item_t in_data,
  input  logic               out_ready,
  output bhpq_pkg::dp_sts_t  sts,
  output logic               out_valid,
  output bhpq_pkg::out_item_t out_data
);
  import bhpq_pkg::*;

  entry_t mem [CAPACITY];

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  entry_t             item_r, item_nxt;
  entry_t             moving_r, moving_nxt;
  entry_t             left_r, left_nxt;
  entry_t             top_r, top_nxt;
  entry_t             rd_data_r;
  logic [1:0]         status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic [IDX_W-1:0]  count_ext;
  logic [IDX_W-1:0]  parent_idx;
  logic [IDX_W-1:0]  left_idx;
  logic [IDX_W-1:0]  right_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  rd_off;
  logic [ADDR_W-1:0] rd_addr;
  logic [IDX_W-1:0]  wr_off;
  logic              wr_en;
  entry_t            wr_data;
  logic              has_right;
  logic              use_right;
  entry_t            chosen;
  entry_t            in_entry;

  assign count_ext  = {1'b0, count_r};
  assign parent_idx = k_r >> 1;
  assign left_idx   = k_r << 1;
  assign right_idx  = (k_r << 1) + IDX_W'(1);
  assign has_right  = right_idx <= count_ext;
  assign use_right  = has_right && !entry_after(rd_data_r, left_r);
  assign chosen     = use_right ? rd_data_r : left_r;

  assign in_entry.position = in_data.item_position;
  assign in_entry.cost     = in_data.item_cost;
  assign in_entry.memory   = in_data.item_memory;

  always_comb begin
    case (cmd.rd_sel)
      RD_LAST:   rd_idx = count_ext;
      RD_PARENT: rd_idx = parent_idx;
      RD_LEFT:   rd_idx = left_idx;
      default:   rd_idx = right_idx;
    endcase
    rd_off  = rd_idx - IDX_W'(1);
    rd_addr = rd_off[ADDR_W-1:0];
    wr_off  = k_r - IDX_W'(1);
  end

  always_comb begin
    sts.full          = count_r == COUNT_W'(CAPACITY);
    sts.empty         = count_r == '0;
    sts.k_is_root     = k_r == IDX_W'(1);
    sts.parent_after  = entry_after(rd_data_r, item_r);
    sts.has_left      = left_idx <= count_ext;
    sts.move_down     = entry_after(moving_r, chosen);
    sts.count_nonzero = count_r != '0;
    sts.out_busy      = out_valid_r && !out_ready;
  end

  always_comb begin
    count_nxt     = count_r;
    k_nxt         = k_r;
    item_nxt      = item_r;
    moving_nxt    = moving_r;
    left_nxt      = left_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    wr_data       = item_r;
    case (cmd.op)
      DP_LOAD_PUSH: begin
        item_nxt   = in_entry;
        k_nxt      = count_ext + IDX_W'(1);
        count_nxt  = count_r + COUNT_W'(1);
        status_nxt = STATUS_OK;
      end
      DP_LOAD_POP: begin
        k_nxt      = IDX_W'(1);
        count_nxt  = count_r - COUNT_W'(1);
        status_nxt = STATUS_OK;
      end
      DP_SET_FULL:  status_nxt = STATUS_FULL;
      DP_SET_EMPTY: status_nxt = STATUS_EMPTY;
      DP_PARENT_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_data_r;
        k_nxt   = parent_idx;
      end
      DP_PUT_ITEM: begin
        wr_en   = 1'b1;
        wr_data = item_r;
      end
      DP_TAKE_MOVING: moving_nxt = rd_data_r;
      DP_LATCH_LEFT:  left_nxt   = rd_data_r;
      DP_CHILD_MOVE: begin
        wr_en   = 1'b1;
        wr_data = chosen;
        k_nxt   = use_right ? right_idx : left_idx;
      end
      DP_PUT_MOVING: begin
        wr_en   = 1'b1;
        wr_data = moving_r;
      end
      DP_LOAD_RESULT: begin
        out_valid_nxt       = 1'b1;
        out_nxt.top_valid   = count_r != '0;
        out_nxt.entry_count = count_r;
        out_nxt.status      = status_r;
        if (count_r != '0) begin
          out_nxt.top_position = top_r.position;
          out_nxt.top_cost     = top_r.cost;
          out_nxt.top_memory   = top_r.memory;
        end else begin
          out_nxt.top_position = '0;
          out_nxt.top_cost     = '0;
          out_nxt.top_memory   = '0;
        end
      end
      default: begin
      end
    endcase
    top_nxt = (wr_en && k_r == IDX_W'(1)) ? wr_data : top_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_off[ADDR_W-1:0]] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    item_r   <= item_nxt;
    moving_r <= moving_nxt;
    left_r   <= left_nxt;
    top_r    <= top_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/binary_heap_priority_queue.sv]
// Binary min-heap priority queue, ordered by cost and then by memory.
// Input channel (in_valid/in_ready/in_data): one transfer carries a push of
// an entry or a pop of the top entry. Output channel (out_valid/out_ready/
// out_data): one transfer per command, giving the top entry afterwards,
// whether one exists, the entry count and a status code.
// One command is worked at a time. The heap store is a single 1024-entry
// RAM with one write and one registered read a cycle. A push climbs with
// one parent read then one compare-and-write per heap level; a pop sinks
// with a left-child read, a right-child read, then one compare-and-write
// per level. A refused push or pop goes straight to the result.
// A result is held in an output register; the next command is taken while
// it waits. If the receiver stalls, the following result holds in its final
// state until the output register frees, and no further command is taken.
// Reset (rst_n low at a clock edge) empties the heap at once; no clearing
// pass runs, since only slots below the entry count are ever used.
module binary_heap_priority_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bhpq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bhpq_pkg::out_item_t out_data
);
  import bhpq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence the sift: one heap level per read/compare round.
  bhpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Hold the store, the count, the working entries and the result register.
  bhpq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[tb/sv/binary_heap_priority_queue_tb.sv]
`timescale 1ns / 100ps

module binary_heap_priority_queue_tb;
  import bhpq_pkg::*;

  // Cycles without any transfer on either channel before the run is abandoned.
  // Pops and long receiver stalls at 80 %
  // stay far below this.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Settling time after the last result: longer than the slowest pop.
  localparam int unsigned TAIL_CYCLES = 40;

  // Shadow copy of the heap: tracks every accepted command and holds the
  // top-of-heap reports that the block still owes.
  class heap_shadow;
    entry_t      slots[CAPACITY];
    int unsigned held;
    out_item_t   expected_tops[$];
    int unsigned fail_count;

    function new();
      held       = 0;
      fail_count = 0;
    endfunction

    // a belongs below b: greater cost, or equal cost and greater memory
    local function bit sits_below(entry_t a, entry_t b);
      if (a.cost == b.cost) begin
        return a.memory > b.memory;
      end
      return a.cost > b.cost;
    endfunction

    function void note_command(in_item_t item);
      entry_t      fresh;
      entry_t      moving;
      int unsigned k;
      int unsigned child;
      logic [1:0]  st;
      out_item_t   want;
      fresh.position = item.item_position;
      fresh.cost     = item.item_cost;
      fresh.memory   = item.item_memory;
      st = STATUS_OK;
      if (item.command == CMD_PUSH) begin
        if (held >= CAPACITY) begin
          st = STATUS_FULL;
        end else begin
          // climb while the parent is strictly greater; equal parents stay put
          held++;
          k = held;
          while (k > 1 && sits_below(slots[k/2 - 1], fresh)) begin
            slots[k - 1] = slots[k/2 - 1];
            k = k / 2;
          end
          slots[k - 1] = fresh;
        end
      end else begin
        if (held == 0) begin
          st = STATUS_EMPTY;
        end else begin
          // last entry goes to the root and sinks; right child wins ties
          moving = slots[held - 1];
          held--;
          k = 1;
          while (2 * k <= held) begin
            child = 2 * k;
            if (child + 1 <= held && !sits_below(slots[child], slots[child - 1])) begin
              child = child + 1;
            end
            if (!sits_below(moving, slots[child - 1])) begin
              break;
            end
            slots[k - 1] = slots[child - 1];
            k = child;
          end
          if (held > 0) begin
            slots[k - 1] = moving;
          end
        end
      end
      want = '0;
      if (held > 0) begin
        want.top_valid    = 1'b1;
        want.top_position = slots[0].position;
        want.top_cost     = slots[0].cost;
        want.top_memory   = slots[0].memory;
      end
      want.entry_count = COUNT_W'(held);
      want.status      = st;
      expected_tops.push_back(want);
    endfunction

    local function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_tops.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_count++;
        return;
      end
      want = expected_tops.pop_front();
      compare_field("top_valid", want.top_valid, got.top_valid);
      compare_field("top_position", want.top_position, got.top_position);
      compare_field("top_cost", want.top_cost, got.top_cost);
      compare_field("top_memory", want.top_memory, got.top_memory);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  heap_shadow  shadow = new();
  // Percentages: sender idle per cycle, receiver stall per cycle.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  binary_heap_priority_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Receiver: drop ready at random at the current stall rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each result transfer against the oldest expectation, and abandon
  // the run if the channels go quiet for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        shadow.check_result(out_data);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("binary_heap_priority_queue_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic in_item_t make_item(logic cmd, int unsigned pos, int unsigned cost,
                                         int unsigned mem);
    in_item_t it;
    it.command       = cmd;
    it.item_position = POS_W'(pos);
    it.item_cost     = COST_W'(cost);
    it.item_memory   = MEM_W'(mem);
    return it;
  endfunction

  // Mixed traffic: keep the heap a few levels deep, and crowd half the keys
  // into a narrow range so that cost and memory ties are frequent.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned push_pct;
    push_pct = (shadow.held < 40) ? 65 : 35;
    it.command       = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
    it.item_position = POS_W'($urandom);
    if ($urandom_range(1) == 1) begin
      it.item_cost   = COST_W'($urandom_range(15));
      it.item_memory = MEM_W'($urandom_range(3));
    end else begin
      it.item_cost   = COST_W'($urandom);
      it.item_memory = MEM_W'($urandom);
    end
    return it;
  endfunction

  // Offer one command and hold it until the transfer; valid is left high so
  // that back-to-back commands need no second assignment in one step.
  task automatic send_command(input in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    shadow.note_command(item);
  endtask

  // Hold off the sender until every owed result has arrived.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (shadow.expected_tops.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic pop_until_empty();
    while (shadow.held > 0) begin
      send_command(make_item(CMD_POP, $urandom, $urandom, $urandom));
    end
  endtask

  task automatic run_directed();
    // pop refused on an empty heap
    send_command(make_item(CMD_POP, 'h3FF, 'hFFFF, 'hFFFF));
    // key extremes, then ties on cost and on both keys
    send_command(make_item(CMD_PUSH, 'h3FF, 'hFFFF, 'hFFFF));
    send_command(make_item(CMD_PUSH, 0, 0, 0));
    send_command(make_item(CMD_PUSH, 5, 0, 1));
    send_command(make_item(CMD_PUSH, 7, 0, 0));
    send_command(make_item(CMD_PUSH, 'h2AA, 'h5555, 'hAAAA));
    send_command(make_item(CMD_PUSH, 'h155, 'hAAAA, 'h5555));
    send_command(make_item(CMD_PUSH, 9, 100, 'h8000));
    send_command(make_item(CMD_PUSH, 10, 100, 'h8000));
    send_command(make_item(CMD_PUSH, 11, 100, 'h8000));
    send_command(make_item(CMD_PUSH, 12, 100, 'h7FFF));
    // drain: equal children exercise the right-child preference
    pop_until_empty();
    send_command(make_item(CMD_POP, 0, 0, 0));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    hold_until_drained();

    // Idling phases: none, sender idle, receiver stalling, both lightly.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 80 : (phase == 3) ? 8 : 0;
      stall_pct = (phase == 2) ? 80 : (phase == 3) ? 8 : 0;
      repeat (110) begin
        send_command(random_item());
      end
      pop_until_empty();
      send_command(make_item(CMD_POP, $urandom, $urandom, $urandom));
      hold_until_drained();
    end

    // Build a deeper heap for longer sift paths, then empty it again.
    idle_pct  = 0;
    stall_pct = 0;
    while (shadow.held < 64) begin
      send_command(make_item(CMD_PUSH, $urandom, $urandom, $urandom));
    end
    send_command(make_item(CMD_POP, 0, 0, 0));
    send_command(make_item(CMD_PUSH, $urandom, 0, 0));
    pop_until_empty();
    send_command(make_item(CMD_POP, 0, 0, 0));

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.fail_count == 0) begin
      $display("binary_heap_priority_queue_tb: PASS");
    end else begin
      $display("binary_heap_priority_queue_tb: FAIL");
    end
    $finish;
  end

endmodule
